// File: hdl/pshc_pkg.sv
// Shared types and constants for the pair-sum histogram convolution block.
package pshc_pkg;

  localparam int OPCODE_W = 2;
  localparam int VAL_W    = 12;
  localparam int CFG_W    = 11;
  localparam int PAIR_W   = 41;

  localparam logic [OPCODE_W-1:0] OP_ADD_FIRST  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_SECOND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 2'd3;

  localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;
  localparam logic [PAIR_W-1:0] PAIR_MAX  = {PAIR_W{1'b1}};

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// File: hdl/pshc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pshc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/pshc_mac.sv
// Registered multiply followed by a saturating accumulate.
module pshc_mac #(
  parameter int COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pshc_pkg::mac_ctrl_t       ctrl,
  input  logic [COUNT_BITS-1:0]     a,
  input  logic [COUNT_BITS-1:0]     b,
  output logic [pshc_pkg::PAIR_W-1:0] acc,
  output logic                      pending
);

  localparam int PROD_W = 2 * COUNT_BITS;
  localparam int SUM_W  = ((PROD_W > pshc_pkg::PAIR_W) ? PROD_W : pshc_pkg::PAIR_W) + 1;

  logic [PROD_W-1:0]           prod_r;
  logic                        prod_vld_r;
  logic [pshc_pkg::PAIR_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0]            sum;

  always_comb begin
    sum = SUM_W'(acc_r) + SUM_W'(prod_r);
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      // Once the total reaches the top of the range it stays there.
      acc_nxt = (sum >= SUM_W'(pshc_pkg::PAIR_MAX)) ? pshc_pkg::PAIR_MAX
                                                    : sum[pshc_pkg::PAIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctrl.valid;
      acc_r      <= acc_nxt;
    end
  end

  assign acc     = acc_r;
  assign pending = prod_vld_r;

endmodule

// File: hdl/pair_sum_histogram_convolution.sv
// Top level: two count histograms in RAM and an exact convolution query engine.
//
// Usage: a command is taken at a rising edge where start is high and busy is
// low. Opcodes add one value to the first or second histogram, clear both,
// or query the number of pairs (one value from each histogram) adding to a
// sum. Only a query produces a result: out_valid is high for exactly one
// cycle with out_pair_count, and the receiver must take it then.
// An add reads the entry, then writes back the incremented count (S_ADD_RD, S_ADD_WR).
// A clear runs a pass that writes zero to every entry of both histograms,
// one entry per cycle.
// A query walks the index range of the sum with one read of each RAM and one
// multiply-accumulate per cycle, then drains the pipeline (S_Q_DRAIN); a sum
// outside 2..2K skips the walk and goes straight to the result.
// After reset the same clearing pass runs, and busy stays high until it ends.
// max_value resets to 1024.
// The cfg channel is always ready; write max_value only while busy is low.
// Counts saturate per entry and pair_count saturates at 2^41 - 1.
module pair_sum_histogram_convolution #(
  parameter int MAX_VALUE  = 1024,
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pshc_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [pshc_pkg::VAL_W-1:0]        in_operand,
  output logic                              out_valid,
  output logic [pshc_pkg::PAIR_W-1:0]       out_pair_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pshc_pkg::CFG_W-1:0]        cfg_max_value
);

  localparam int DEPTH  = MAX_VALUE + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VW     = pshc_pkg::VAL_W;
  localparam int CW     = pshc_pkg::CFG_W;
  localparam logic [16:0] MAXV = 17'(MAX_VALUE);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_ADD_RD  = 3'd2;
  localparam logic [2:0] S_ADD_WR  = 3'd3;
  localparam logic [2:0] S_Q_SETUP = 3'd4;
  localparam logic [2:0] S_Q_RUN   = 3'd5;
  localparam logic [2:0] S_Q_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]                        state_r, state_nxt;
  logic [ADDR_W-1:0]                 clr_r, clr_nxt;
  logic [pshc_pkg::OPCODE_W-1:0]     op_r, op_nxt;
  logic [VW-1:0]                     opnd_r, opnd_nxt;
  logic [VW-1:0]                     i_r, i_nxt, j_r, j_nxt, hi_r, hi_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]                     max_value_r;

  logic [CW-1:0]         k_lo, k_sat;
  logic [VW-1:0]         k;
  logic [VW:0]           two_k;
  logic                  val_ok, sum_ok;
  logic [VW-1:0]         lo, hi;
  logic [COUNT_BITS-1:0] rdata_a, rdata_b, sel, inc;
  logic                  we_a, we_b;
  logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
  logic [COUNT_BITS-1:0] wdata;
  pshc_pkg::mac_ctrl_t   mac_ctrl;
  logic [pshc_pkg::PAIR_W-1:0] acc;
  logic                  mac_pending;

  // Effective K: zero acts as one, anything above MAX_VALUE acts as MAX_VALUE.
  always_comb begin
    k_lo  = (max_value_r == '0) ? CW'(1) : max_value_r;
    k_sat = ({6'd0, k_lo} > MAXV) ? MAXV[CW-1:0] : k_lo;
    k     = {1'b0, k_sat};
    two_k = {k, 1'b0};
  end

  always_comb begin
    val_ok = (opnd_r != '0) && (opnd_r <= k);
    sum_ok = (opnd_r >= VW'(2)) && ({1'b0, opnd_r} <= two_k);
    lo     = (opnd_r > k) ? (opnd_r - k) : VW'(1);
    hi     = ((opnd_r - VW'(1)) < k) ? (opnd_r - VW'(1)) : k;
  end

  always_comb begin
    sel = (op_r == pshc_pkg::OP_ADD_SECOND) ? rdata_b : rdata_a;
    inc = (&sel) ? sel : sel + COUNT_BITS'(1);
  end

  always_comb begin
    we_a    = (state_r == S_CLEAR) ||
              ((state_r == S_ADD_WR) && val_ok && (op_r == pshc_pkg::OP_ADD_FIRST));
    we_b    = (state_r == S_CLEAR) ||
              ((state_r == S_ADD_WR) && val_ok && (op_r == pshc_pkg::OP_ADD_SECOND));
    waddr   = (state_r == S_CLEAR) ? clr_r : ADDR_W'(opnd_r);
    wdata   = (state_r == S_CLEAR) ? '0 : inc;
    raddr_a = (state_r == S_Q_RUN) ? ADDR_W'(i_r) : ADDR_W'(opnd_r);
    raddr_b = (state_r == S_Q_RUN) ? ADDR_W'(j_r) : ADDR_W'(opnd_r);
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    opnd_nxt   = opnd_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    hi_nxt     = hi_r;
    rd_vld_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAX_VALUE)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_opcode;
          opnd_nxt = in_operand;
          unique case (in_opcode)
            pshc_pkg::OP_ADD_FIRST,
            pshc_pkg::OP_ADD_SECOND: state_nxt = S_ADD_RD;
            pshc_pkg::OP_CLEAR: begin
              state_nxt = S_CLEAR;
              clr_nxt   = '0;
            end
            pshc_pkg::OP_QUERY: state_nxt = S_Q_SETUP;
          endcase
        end
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_IDLE;
      S_Q_SETUP: begin
        if (sum_ok) begin
          i_nxt     = lo;
          j_nxt     = opnd_r - lo;
          hi_nxt    = hi;
          state_nxt = S_Q_RUN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_Q_RUN: begin
        rd_vld_nxt = 1'b1;
        i_nxt      = i_r + VW'(1);
        j_nxt      = j_r - VW'(1);
        if (i_r == hi_r) begin
          state_nxt = S_Q_DRAIN;
        end
      end
      S_Q_DRAIN: begin
        // Wait for the last reads and products to reach the accumulator.
        if (!rd_vld_r && !mac_pending) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    opnd_r <= opnd_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    hi_r   <= hi_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      max_value_r <= pshc_pkg::CFG_RESET;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        max_value_r <= cfg_max_value;
      end
    end
  end

  pshc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  pshc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_comb begin
    mac_ctrl.clear = (state_r == S_Q_SETUP);
    mac_ctrl.valid = rd_vld_r;
  end

  pshc_mac #(.COUNT_BITS(COUNT_BITS)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .a       (rdata_a),
    .b       (rdata_b),
    .acc     (acc),
    .pending (mac_pending)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_DONE);
  assign out_pair_count = acc;
  assign cfg_ready      = 1'b1;

endmodule

// File: hdl/pshc_checker.sv
// Port-level checker for the pair-sum histogram convolution block, with its bind.
module pshc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A result only appears while a command is still in progress.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result strobe while idle");

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // An accepted command leaves the block busy once it has been taken.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted command left the block idle");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (start && !busy) |=> !out_valid)
    else $error("result in the cycle after a command was taken");

  // The clearing pass after reset keeps the block busy.
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

endmodule

bind pair_sum_histogram_convolution pshc_checker u_pshc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
